>>> sv/lcb_pkg.sv
// Shared types and constants for the LED command blink controller.
package lcb_pkg;

    // Number of LED channels and color codes
    localparam int LED_COUNT = 4;
    localparam logic [3:0] COLOR_FIRST = 4'd1;
    localparam logic [3:0] COLOR_LAST = 4'(LED_COUNT);
    localparam logic [3:0] COLOR_ALL = 4'(LED_COUNT + 1);

    // Action codes
    localparam logic [3:0] ACT_ON = 4'd1;
    localparam logic [3:0] ACT_OFF = 4'd2;
    localparam logic [3:0] ACT_TOGGLE = 4'd3;
    localparam logic [3:0] ACT_BLINK = 4'd4;

    // Field widths
    localparam int TICK_W = 32;
    localparam int UNITS_W = 4;
    localparam int TPU_W = 16;
    localparam int LIMIT_W = UNITS_W + TPU_W;

    // Configuration register map (register index taken from paddr[2])
    localparam int APB_ADDR_W = 3;
    localparam logic REG_TICKS_PER_UNIT = 1'b0;
    localparam logic [TPU_W-1:0] TPU_RESET = 16'd100;

    // Command broadcast to every LED channel
    typedef struct packed {
        logic [3:0] action;
        logic [UNITS_W-1:0] period;
        logic [TICK_W-1:0] now;
    } lcb_cmd_t;

    // Per-channel state after the command and blink check
    typedef struct packed {
        logic led;
        logic blink;
    } lcb_stat_t;

endpackage

>>> sv/lcb_cfg.sv
// APB configuration register block holding ticks_per_unit.
module lcb_cfg
(
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [lcb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    output logic [lcb_pkg::TPU_W-1:0] ticks_per_unit
);

    logic [lcb_pkg::TPU_W-1:0] tpu_reg;
    logic wr_en;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite
                   && (paddr[2] == lcb_pkg::REG_TICKS_PER_UNIT);

    // Register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpu_reg <= lcb_pkg::TPU_RESET;
        end
        else if (wr_en)
        begin
            tpu_reg <= pwdata[lcb_pkg::TPU_W-1:0];
        end
    end

    // Register read
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == lcb_pkg::REG_TICKS_PER_UNIT)
        begin
            prdata = {{(32 - lcb_pkg::TPU_W){1'b0}}, tpu_reg};
        end
    end

    assign ticks_per_unit = tpu_reg;

endmodule

>>> sv/lcb_channel.sv
// One LED channel: drive bit, blink enable, blink period and blink start time.
module lcb_channel
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic apply,
    input  lcb_pkg::lcb_cmd_t cmd,
    input  logic [lcb_pkg::TPU_W-1:0] ticks_per_unit,
    output lcb_pkg::lcb_stat_t stat
);

    logic led_reg;
    logic led_next;
    logic blink_reg;
    logic [lcb_pkg::UNITS_W-1:0] units_reg;
    logic [lcb_pkg::TICK_W-1:0] start_reg;
    logic [lcb_pkg::TICK_W-1:0] start_next;

    logic led_after;
    logic blink_after;
    logic [lcb_pkg::UNITS_W-1:0] units_after;
    logic [lcb_pkg::LIMIT_W-1:0] limit;
    logic [lcb_pkg::TICK_W-1:0] elapsed;
    logic fire;

    // Apply the command when this channel is selected.
    always_comb
    begin
        led_after = led_reg;
        blink_after = blink_reg;
        units_after = units_reg;
        if (apply)
        begin
            case (cmd.action)
                lcb_pkg::ACT_ON:
                begin
                    led_after = 1'b1;
                    blink_after = 1'b0;
                end
                lcb_pkg::ACT_OFF:
                begin
                    led_after = 1'b0;
                    blink_after = 1'b0;
                end
                lcb_pkg::ACT_TOGGLE:
                begin
                    led_after = ~led_reg;
                    blink_after = 1'b0;
                end
                lcb_pkg::ACT_BLINK:
                begin
                    blink_after = 1'b1;
                    units_after = cmd.period;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Blink check: toggle once the elapsed time exceeds period times ticks_per_unit.
    assign limit = lcb_pkg::LIMIT_W'(units_after) * lcb_pkg::LIMIT_W'(ticks_per_unit);
    assign elapsed = cmd.now - start_reg;
    assign fire = blink_after
                  && (elapsed > {{(lcb_pkg::TICK_W - lcb_pkg::LIMIT_W){1'b0}}, limit});
    assign led_next = led_after ^ fire;
    assign start_next = (!blink_after || fire) ? cmd.now : start_reg;

    // Channel state update, once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg <= 1'b0;
            blink_reg <= 1'b0;
            units_reg <= '0;
            start_reg <= '0;
        end
        else if (step)
        begin
            led_reg <= led_next;
            blink_reg <= blink_after;
            units_reg <= units_after;
            start_reg <= start_next;
        end
    end

    assign stat.led = led_next;
    assign stat.blink = blink_after;

endmodule

>>> sv/led_command_blink_controller.sv
// A request passes through the input register and then the result register.
// Throughput: one request per cycle while m_axis_tready is high.
// The input register refills in the same cycle it drains, so there are no bubbles.
// Reset: all LEDs off, blinking stopped, periods and start times zero,
// ticks_per_unit 100, both pipeline registers empty.
module led_command_blink_controller
(
    input  logic clk,
    input  logic rst_n,
    // APB configuration port
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [lcb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    // Request stream
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // color[3:0], action[7:4], period[11:8], now[43:12]
    // Result stream
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [7:0] m_axis_tdata    // leds[3:0], blinking[7:4]
);

    localparam int N = lcb_pkg::LED_COUNT;

    logic [lcb_pkg::TPU_W-1:0] ticks_per_unit;

    logic in_valid_reg;
    logic in_valid_next;
    logic [3:0] color_reg;
    logic [3:0] action_reg;
    logic [lcb_pkg::UNITS_W-1:0] period_reg;
    logic [lcb_pkg::TICK_W-1:0] now_reg;

    logic out_valid_reg;
    logic out_valid_next;
    logic [N-1:0] leds_reg;
    logic [N-1:0] blinking_reg;

    logic accept;
    logic advance;
    logic cmd_ok;
    logic [N-1:0] sel;
    logic [N-1:0] leds_new;
    logic [N-1:0] blinking_new;
    lcb_pkg::lcb_cmd_t cmd;
    lcb_pkg::lcb_stat_t stat [N];

    // Configuration registers
    lcb_cfg u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .ticks_per_unit (ticks_per_unit)
    );

    // Handshake: the input register moves on whenever the result register is empty or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            color_reg <= s_axis_tdata[3:0];
            action_reg <= s_axis_tdata[7:4];
            period_reg <= s_axis_tdata[11:8];
            now_reg <= s_axis_tdata[43:12];
        end
    end

    // Color decode: one LED, all LEDs, or none for an invalid color.
    always_comb
    begin
        sel = '0;
        if (color_reg inside {[lcb_pkg::COLOR_FIRST:lcb_pkg::COLOR_LAST]})
        begin
            sel = N'(1) << (color_reg - lcb_pkg::COLOR_FIRST);
        end
        else if (color_reg == lcb_pkg::COLOR_ALL)
        begin
            sel = '1;
        end
        cmd_ok = action_reg inside {[lcb_pkg::ACT_ON:lcb_pkg::ACT_BLINK]};
    end

    assign cmd.action = action_reg;
    assign cmd.period = period_reg;
    assign cmd.now = now_reg;

    // LED channels, all updated in parallel
    for (genvar i = 0; i < N; i++)
    begin : g_chan
        lcb_channel u_chan
        (
            .clk            (clk),
            .rst_n          (rst_n),
            .step           (advance),
            .apply          (sel[i] && cmd_ok),
            .cmd            (cmd),
            .ticks_per_unit (ticks_per_unit),
            .stat           (stat[i])
        );
        assign leds_new[i] = stat[i].led;
        assign blinking_new[i] = stat[i].blink;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            leds_reg <= leds_new;
            blinking_reg <= blinking_new;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {blinking_reg, leds_reg};

    // A processed request always lands in the result register.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request did not produce a result");

    // A stalled result must never be overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !advance)
        else $error("stalled result overwritten");

    // A held request stays in the input register until processed.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(now_reg)))
        else $error("pending request lost");

endmodule
